// File: src/bbat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbat_pkg
// Types and constants shared by the bounding box accumulate/transform block.
// ----------------------------------------------------------------------------
package bbat_pkg;

  localparam int NUM_AXES  = 3;
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 8;
  localparam int ROW_W     = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  // Register indexes (byte address / 8)
  localparam logic [1:0] REG_ROW_X = 2'd0;
  localparam logic [1:0] REG_ROW_Y = 2'd1;
  localparam logic [1:0] REG_ROW_Z = 2'd2;

  localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_XFORM = 2'd2
  } bbat_cmd_e;

  typedef logic [NUM_AXES-1:0][ROW_W-1:0] bbat_rows_t;

  // Control travelling with an item from the product stage to the result stage
  typedef struct packed {
    logic xform;  // result comes from the summed products
    logic empty;  // empty flag of the result
  } bbat_ctrl_t;

endpackage
`default_nettype wire

// File: src/bounding_box_accumulate_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounding_box_accumulate_transform
// Registers: input, product and result, in that order; one item per cycle
//   while the output is not stalled.
// The transform's corner products are computed in parallel, 18 multipliers.
// Reset: asynchronous, active low; the box is emptied and the matrix rows
//   return to identity. Stalls on the output back up stage by stage.
// ----------------------------------------------------------------------------
module bounding_box_accumulate_transform #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          s_axis_tvalid,
  output logic                                               s_axis_tready,
  // point_x, point_y, point_z (from bit 0 up), zero padded to bytes
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
  // command
  input  wire logic [1:0]                                    s_axis_tuser,
  output logic                                               m_axis_tvalid,
  input  wire logic                                          m_axis_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z (from bit 0 up), zero padded
  output logic      [((6*COORD_WIDTH+7)/8)*8-1:0]            m_axis_tdata,
  // is_empty
  output logic      [0:0]                                    m_axis_tuser,
  input  wire logic                                          psel,
  input  wire logic                                          penable,
  input  wire logic                                          pwrite,
  input  wire logic [bbat_pkg::CFG_ADDR_W-1:0]               paddr,
  input  wire logic [bbat_pkg::CFG_DATA_W-1:0]               pwdata,
  output logic      [bbat_pkg::CFG_DATA_W-1:0]               prdata,
  output logic                                               pready
);
  import bbat_pkg::*;

  localparam int ProdW = COEF_W + COORD_WIDTH;
  localparam int OutW  = ((6*COORD_WIDTH+7)/8)*8;

  bbat_rows_t                                    rows;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]          in_point;
  logic                                          prod_valid, prod_ready;
  bbat_ctrl_t                                    prod_ctrl;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]          box_lo, box_hi;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][ProdW-1:0]  prod_lo, prod_hi;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]          out_lo, out_hi;
  logic                                          out_empty;

  assign in_point = s_axis_tdata[NUM_AXES*COORD_WIDTH-1:0];

  bbat_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows_o  (rows)
  );

  bbat_box_stage #(
    .CoordW (COORD_WIDTH),
    .ProdW  (ProdW)
  ) u_box (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_point_i   (in_point),
    .rows_i       (rows),
    .prod_ready_i (prod_ready),
    .prod_valid_o (prod_valid),
    .prod_ctrl_o  (prod_ctrl),
    .box_lo_o     (box_lo),
    .box_hi_o     (box_hi),
    .prod_lo_o    (prod_lo),
    .prod_hi_o    (prod_hi)
  );

  bbat_result_stage #(
    .CoordW (COORD_WIDTH),
    .ProdW  (ProdW)
  ) u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_ctrl_i  (prod_ctrl),
    .box_lo_i     (box_lo),
    .box_hi_i     (box_hi),
    .prod_lo_i    (prod_lo),
    .prod_hi_i    (prod_hi),
    .rows_i       (rows),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_lo_o     (out_lo),
    .out_hi_o     (out_hi),
    .out_empty_o  (out_empty)
  );

  assign m_axis_tdata = OutW'({out_hi, out_lo});
  assign m_axis_tuser = out_empty;

endmodule
`default_nettype wire

// File: src/bbat_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbat_cfg_regs
// APB register file holding the three affine matrix rows.
// ----------------------------------------------------------------------------
module bbat_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bbat_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [bbat_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [bbat_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output bbat_pkg::bbat_rows_t                     rows_o
);
  import bbat_pkg::*;

  logic [1:0]  reg_idx;
  logic        wr_en;
  bbat_rows_t  rows_q;

  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign rows_o  = rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[0] <= ROW_X_RESET;
      rows_q[1] <= ROW_Y_RESET;
      rows_q[2] <= ROW_Z_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROW_X: rows_q[0] <= pwdata;
        REG_ROW_Y: rows_q[1] <= pwdata;
        REG_ROW_Z: rows_q[2] <= pwdata;
        default: ;  // drop writes beyond the last row
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_X: prdata = rows_q[0];
      REG_ROW_Y: prdata = rows_q[1];
      REG_ROW_Z: prdata = rows_q[2];
      default:   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/bbat_box_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbat_box_stage
// Input register, stored box update, corner-selecting multipliers and the product register.
// ----------------------------------------------------------------------------
module bbat_box_stage #(
  parameter int CoordW = 16,
  parameter int ProdW  = 32
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           in_valid_i,
  output logic                                                in_ready_o,
  input  wire logic [1:0]                                     in_cmd_i,
  input  wire logic [bbat_pkg::NUM_AXES-1:0][CoordW-1:0]      in_point_i,
  input  wire bbat_pkg::bbat_rows_t                           rows_i,
  input  wire logic                                           prod_ready_i,
  output logic                                                prod_valid_o,
  output bbat_pkg::bbat_ctrl_t                                prod_ctrl_o,
  output logic      [bbat_pkg::NUM_AXES-1:0][CoordW-1:0]      box_lo_o,
  output logic      [bbat_pkg::NUM_AXES-1:0][CoordW-1:0]      box_hi_o,
  output logic      [bbat_pkg::NUM_AXES-1:0][bbat_pkg::NUM_AXES-1:0][ProdW-1:0] prod_lo_o,
  output logic      [bbat_pkg::NUM_AXES-1:0][bbat_pkg::NUM_AXES-1:0][ProdW-1:0] prod_hi_o
);
  import bbat_pkg::*;

  localparam logic [CoordW-1:0] COORD_MAX = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] COORD_MIN = {1'b1, {(CoordW-1){1'b0}}};

  logic                              s0_vld_q;
  logic [1:0]                        s0_cmd_q;
  logic [NUM_AXES-1:0][CoordW-1:0]   s0_pt_q;
  logic                              s0_ready;
  logic                              s0_adv;
  logic                              s1_ready;

  logic [NUM_AXES-1:0][CoordW-1:0]   lo_q, hi_q, lo_d, hi_d;
  logic                              empty_now, empty_next;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][ProdW-1:0] mul_lo, mul_hi;

  logic                              s1_vld_q;
  bbat_ctrl_t                        s1_ctrl_q;
  logic [NUM_AXES-1:0][CoordW-1:0]   s1_lo_q, s1_hi_q;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][ProdW-1:0] s1_plo_q, s1_phi_q;

  assign s1_ready   = !s1_vld_q || prod_ready_i;
  assign s0_ready   = !s0_vld_q || s1_ready;
  assign s0_adv     = s0_vld_q && s1_ready;
  assign in_ready_o = s0_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (s0_ready) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && in_valid_i) begin
      s0_cmd_q <= in_cmd_i;
      s0_pt_q  <= in_point_i;
    end
  end

  // Box update
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    case (bbat_cmd_e'(s0_cmd_q))
      CMD_CLEAR: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          lo_d[a] = COORD_MAX;
          hi_d[a] = COORD_MIN;
        end
      end
      CMD_ADD: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          if ($signed(s0_pt_q[a]) < $signed(lo_q[a])) lo_d[a] = s0_pt_q[a];
          if ($signed(s0_pt_q[a]) > $signed(hi_q[a])) hi_d[a] = s0_pt_q[a];
        end
      end
      default: ;  // transform and unused codes leave the box alone
    endcase
  end

  assign empty_now  = $signed(lo_q[0]) > $signed(hi_q[0]);
  assign empty_next = $signed(lo_d[0]) > $signed(hi_d[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        lo_q[a] <= COORD_MAX;
        hi_q[a] <= COORD_MIN;
      end
    end else if (s0_adv) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // A non-negative coefficient takes its minimum at the low corner, a negative
  // one at the high corner; the sums split per input axis.
  always_comb begin
    logic signed [COEF_W-1:0] c;
    logic signed [CoordW-1:0] sel_lo;
    logic signed [CoordW-1:0] sel_hi;
    c      = '0;
    sel_lo = '0;
    sel_hi = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        c      = rows_i[a][k*COEF_W +: COEF_W];
        sel_lo = c[COEF_W-1] ? hi_q[k] : lo_q[k];
        sel_hi = c[COEF_W-1] ? lo_q[k] : hi_q[k];
        mul_lo[a][k] = ProdW'(c * sel_lo);
        mul_hi[a][k] = ProdW'(c * sel_hi);
      end
    end
  end

  // Product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_adv) begin
      s1_ctrl_q.xform <= (bbat_cmd_e'(s0_cmd_q) == CMD_XFORM) && !empty_now;
      s1_ctrl_q.empty <= empty_next;
      s1_lo_q         <= lo_d;
      s1_hi_q         <= hi_d;
      s1_plo_q        <= mul_lo;
      s1_phi_q        <= mul_hi;
    end
  end

  assign prod_valid_o = s1_vld_q;
  assign prod_ctrl_o  = s1_ctrl_q;
  assign box_lo_o     = s1_lo_q;
  assign box_hi_o     = s1_hi_q;
  assign prod_lo_o    = s1_plo_q;
  assign prod_hi_o    = s1_phi_q;

endmodule
`default_nettype wire

// File: src/bbat_result_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbat_result_stage
// Row sums, rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module bbat_result_stage #(
  parameter int CoordW = 16,
  parameter int ProdW  = 32
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           prod_valid_i,
  output logic                                                prod_ready_o,
  input  wire bbat_pkg::bbat_ctrl_t                           prod_ctrl_i,
  input  wire logic [bbat_pkg::NUM_AXES-1:0][CoordW-1:0]      box_lo_i,
  input  wire logic [bbat_pkg::NUM_AXES-1:0][CoordW-1:0]      box_hi_i,
  input  wire logic [bbat_pkg::NUM_AXES-1:0][bbat_pkg::NUM_AXES-1:0][ProdW-1:0] prod_lo_i,
  input  wire logic [bbat_pkg::NUM_AXES-1:0][bbat_pkg::NUM_AXES-1:0][ProdW-1:0] prod_hi_i,
  input  wire bbat_pkg::bbat_rows_t                           rows_i,
  output logic                                                out_valid_o,
  input  wire logic                                           out_ready_i,
  output logic      [bbat_pkg::NUM_AXES-1:0][CoordW-1:0]      out_lo_o,
  output logic      [bbat_pkg::NUM_AXES-1:0][CoordW-1:0]      out_hi_o,
  output logic                                                out_empty_o
);
  import bbat_pkg::*;

  localparam int AccW = ProdW + 2;
  localparam logic signed [AccW-1:0] HALF   = AccW'(1 << (FRAC_BITS - 1));
  localparam logic signed [AccW-1:0] SAT_HI = {{(AccW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SAT_LO = {{(AccW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}};

  function automatic logic [CoordW-1:0] round_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] q;
    logic [CoordW-1:0]      r;
    q = (acc + HALF) >>> FRAC_BITS;
    if (q > SAT_HI) begin
      r = SAT_HI[CoordW-1:0];
    end else if (q < SAT_LO) begin
      r = SAT_LO[CoordW-1:0];
    end else begin
      r = q[CoordW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [AccW-1:0] ext(input logic [ProdW-1:0] p);
    return {{2{p[ProdW-1]}}, p};
  endfunction

  logic                              out_vld_q;
  logic [NUM_AXES-1:0][CoordW-1:0]   out_lo_q, out_hi_q;
  logic                              out_empty_q;
  logic [NUM_AXES-1:0][CoordW-1:0]   xf_lo, xf_hi;

  assign prod_ready_o = !out_vld_q || out_ready_i;

  always_comb begin
    logic signed [AccW-1:0] trans;
    logic signed [AccW-1:0] acc_lo;
    logic signed [AccW-1:0] acc_hi;
    logic [COEF_W-1:0]      t;
    trans  = '0;
    acc_lo = '0;
    acc_hi = '0;
    t      = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      t      = rows_i[a][NUM_AXES*COEF_W +: COEF_W];
      trans  = {{(AccW-COEF_W-FRAC_BITS){t[COEF_W-1]}}, t, {FRAC_BITS{1'b0}}};
      acc_lo = ext(prod_lo_i[a][0]) + ext(prod_lo_i[a][1]) + ext(prod_lo_i[a][2]) + trans;
      acc_hi = ext(prod_hi_i[a][0]) + ext(prod_hi_i[a][1]) + ext(prod_hi_i[a][2]) + trans;
      xf_lo[a] = round_sat(acc_lo);
      xf_hi[a] = round_sat(acc_hi);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (prod_ready_o) begin
      out_vld_q <= prod_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_ready_o && prod_valid_i) begin
      out_lo_q    <= prod_ctrl_i.xform ? xf_lo : box_lo_i;
      out_hi_q    <= prod_ctrl_i.xform ? xf_hi : box_hi_i;
      out_empty_q <= prod_ctrl_i.empty;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_lo_o    = out_lo_q;
  assign out_hi_o    = out_hi_q;
  assign out_empty_o = out_empty_q;

endmodule
`default_nettype wire
